// ----- design/fcd_pkg.sv -----
// Package for the FIFO call dispatcher: field widths, codes, reset values and shared types.
// No dependencies; every other design file but fcd_ram uses it by scoped names.
`default_nettype none
package fcd_pkg;

  // Default sizes handed to the top level
  localparam int QUEUE_DEPTH_DEF = 128;
  localparam int MAX_SERVERS_DEF = 8;
  // A tick never gives more results than this
  localparam int RESULT_LIMIT    = 8;

  // Field widths
  localparam int ID_W       = 16;
  localparam int TIME_W     = 16;
  localparam int TOTAL_W    = 32;
  localparam int LEVEL_W    = 8;
  localparam int SRV_IDX_W  = 3;
  localparam int SRV_CNT_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Request codes
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_TIME   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVERS_IN_USE = 1'd1;

  // Configuration reset values
  localparam logic [TIME_W-1:0]    SERVICE_TIME_RST = 16'd10;
  localparam logic [SRV_CNT_W-1:0] SERVERS_RST      = 4'd8;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // One server's stored state
  typedef struct packed {
    logic               busy;
    logic [TIME_W-1:0]  time_left;
    logic [TOTAL_W-1:0] total;
  } srv_rec_t;

  // Queue control from the sequencer
  typedef struct packed {
    logic push;  // write the incoming id at the tail
    logic pop;   // drop the head entry
    logic rd;    // fetch the head entry (after this cycle's pop)
  } qcmd_t;

endpackage
`default_nettype wire

// ----- design/fcd_in_if.sv -----
// Input channel of the FIFO call dispatcher: valid/ready handshake with request payload.
// Depends on fcd_pkg for field widths.
`default_nettype none
interface fcd_in_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [fcd_pkg::ID_W-1:0] call_id;

  modport source (output valid, req_type, call_id, input ready);
  modport sink   (input valid, req_type, call_id, output ready);
endinterface
`default_nettype wire

// ----- design/fcd_out_if.sv -----
// Result channel of the FIFO call dispatcher: valid/ready handshake with status payload.
// Depends on fcd_pkg for field widths.
`default_nettype none
interface fcd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          enqueue_accepted;
  logic [fcd_pkg::SRV_IDX_W-1:0] server_index;
  logic                          call_assigned;
  logic [fcd_pkg::ID_W-1:0]      assigned_call_id;
  logic                          server_busy;
  logic [fcd_pkg::TOTAL_W-1:0]   calls_handled;
  logic [fcd_pkg::LEVEL_W-1:0]   queue_level;
  logic                          last_result;

  modport source (output valid, enqueue_accepted, server_index, call_assigned,
                  assigned_call_id, server_busy, calls_handled, queue_level,
                  last_result, input ready);
  modport sink   (input valid, enqueue_accepted, server_index, call_assigned,
                  assigned_call_id, server_busy, calls_handled, queue_level,
                  last_result, output ready);
endinterface
`default_nettype wire

// ----- design/fcd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/fcd_call_queue.sv -----
// Ring FIFO of call ids: head/tail/count control around one fcd_ram.
// Depends on fcd_pkg and fcd_ram.
`default_nettype none
module fcd_call_queue #(
  parameter int QUEUE_DEPTH = fcd_pkg::QUEUE_DEPTH_DEF,
  localparam int QAW  = $clog2(QUEUE_DEPTH),
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire fcd_pkg::qcmd_t           cmd,
  input  wire logic [fcd_pkg::ID_W-1:0] push_id,
  output logic      [CNTW-1:0]          count,
  output logic      [fcd_pkg::ID_W-1:0] head_id
);

  localparam logic [QAW-1:0] LAST_SLOT = QAW'(QUEUE_DEPTH - 1);

  logic [QAW-1:0]  head_r, head_nxt;
  logic [QAW-1:0]  tail_r, tail_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [QAW-1:0]  head_inc, tail_inc;
  logic [QAW-1:0]  rd_addr;

  // Ring advance
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;

  always_comb begin
    head_nxt  = cmd.pop  ? head_inc : head_r;
    tail_nxt  = cmd.push ? tail_inc : tail_r;
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Fetch the entry that will be the head next cycle
  assign rd_addr = head_nxt;

  fcd_ram #(
    .WIDTH (fcd_pkg::ID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail_r),
    .wdata (push_id),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (head_id)
  );

  assign count = count_r;

endmodule
`default_nettype wire

// ----- design/fcd_server_store.sv -----
// Server state memory (busy, time left, call total) with per-entry valid bits.
// Entries never written read as all zero. Depends on fcd_pkg and fcd_ram.
`default_nettype none
module fcd_server_store #(
  parameter int NSRV = fcd_pkg::MAX_SERVERS_DEF,
  localparam int SAW = (NSRV > 1) ? $clog2(NSRV) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [SAW-1:0]    rd_idx,
  input  wire logic              wr_en,
  input  wire logic [SAW-1:0]    wr_idx,
  input  wire fcd_pkg::srv_rec_t wr_rec,
  output fcd_pkg::srv_rec_t      rd_rec
);

  localparam int RW = $bits(fcd_pkg::srv_rec_t);

  logic [NSRV-1:0] vld_r;
  logic            rd_vld_r;
  logic [RW-1:0]   ram_rdata;

  // Track written entries; capture validity alongside the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  fcd_ram #(
    .WIDTH (RW),
    .DEPTH (NSRV)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_rec),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  assign rd_rec = rd_vld_r ? fcd_pkg::srv_rec_t'(ram_rdata) : '0;

endmodule
`default_nettype wire

// ----- design/fifo_call_dispatcher.sv -----
// FIFO call dispatcher top level: sequencer, configuration and result register.
// Enqueue: the result is registered on accept; the next item can follow at once while
//   the receiver is ready. Tick: server 0 and the queue head are fetched first, then
//   each visited server in turn, one server read per cycle while results are taken.
// One item is in flight at a time. Reset (rst_n, synchronous) clears queue pointers and
// server valid bits and restores the configuration defaults; no clearing pass is needed.
`default_nettype none
module fifo_call_dispatcher #(
  parameter int QUEUE_DEPTH = fcd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_SERVERS = fcd_pkg::MAX_SERVERS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  fcd_in_if.sink                              in_ch,
  fcd_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [fcd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [fcd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NSRV = (MAX_SERVERS < fcd_pkg::RESULT_LIMIT) ? MAX_SERVERS
                                                               : fcd_pkg::RESULT_LIMIT;
  localparam int SAW  = (NSRV > 1) ? $clog2(NSRV) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int SCW  = fcd_pkg::SRV_CNT_W;
  localparam int TW   = fcd_pkg::TIME_W;
  localparam int SIW  = fcd_pkg::SRV_IDX_W;
  localparam int LVW  = fcd_pkg::LEVEL_W;
  localparam logic [SCW-1:0]  NSRV_C = SCW'(NSRV);
  localparam logic [CNTW-1:0] QFULL  = CNTW'(QUEUE_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_PROC
  } state_t;

  // Configuration registers
  logic [TW-1:0]  service_r;
  logic [SCW-1:0] servers_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      service_r <= fcd_pkg::SERVICE_TIME_RST;
      servers_r <= fcd_pkg::SERVERS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fcd_pkg::CFG_SERVICE_TIME:   service_r <= cfg_data;
        fcd_pkg::CFG_SERVERS_IN_USE: servers_r <= cfg_data[SCW-1:0];
        default: ;
      endcase
    end
  end

  state_t                    state_r, state_nxt;
  logic [SAW-1:0]            idx_r, idx_nxt;
  logic [SAW-1:0]            last_r, last_nxt;
  logic                      out_vld_r, out_vld_nxt;
  logic                      out_acc_r, out_acc_nxt;
  logic [SIW-1:0]            out_sidx_r, out_sidx_nxt;
  logic                      out_asg_r, out_asg_nxt;
  logic [fcd_pkg::ID_W-1:0]  out_aid_r, out_aid_nxt;
  logic                      out_busy_r, out_busy_nxt;
  logic [fcd_pkg::TOTAL_W-1:0] out_tot_r, out_tot_nxt;
  logic [LVW-1:0]            out_lvl_r, out_lvl_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      out_free, in_acc, is_tick, proc_go, is_last;
  logic                      q_full, q_empty, take, busy1;
  logic [TW-1:0]             load, t1;
  logic [SCW-1:0]            n_lim;
  logic [CNTW-1:0]           q_count;
  logic [fcd_pkg::ID_W-1:0]  q_head;
  fcd_pkg::qcmd_t            qcmd;
  fcd_pkg::srv_rec_t         srv_rd, srv_wr;
  logic                      srv_rd_en;
  logic [SAW-1:0]            srv_rd_idx;

  // Handshake
  assign out_free    = !out_vld_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_tick     = (in_ch.req_type == fcd_pkg::REQ_TICK);
  assign proc_go     = (state_r == ST_PROC) && out_free;
  assign is_last     = (idx_r == last_r);

  assign q_full  = (q_count == QFULL);
  assign q_empty = (q_count == '0);

  // Servers visited per tick and service load, with zero treated as one
  always_comb begin
    n_lim = (servers_r == '0) ? SCW'(1) : servers_r;
    if (n_lim > NSRV_C) begin
      n_lim = NSRV_C;
    end
  end
  assign load = (service_r == '0) ? TW'(1) : service_r;

  // Count down the visited server, then let a free server take the head call
  always_comb begin
    if (srv_rd.busy) begin
      t1    = (srv_rd.time_left != '0) ? srv_rd.time_left - 1'b1 : '0;
      busy1 = (t1 != '0);
    end else begin
      t1    = srv_rd.time_left;
      busy1 = 1'b0;
    end
    take             = !busy1 && !q_empty;
    srv_wr.busy      = busy1 || take;
    srv_wr.time_left = take ? load : t1;
    srv_wr.total     = (take && srv_rd.total != fcd_pkg::TOTAL_MAX) ? srv_rd.total + 1'b1
                                                                   : srv_rd.total;
  end

  // Memory requests
  assign qcmd.push  = in_acc && !is_tick && !q_full;
  assign qcmd.pop   = proc_go && take;
  assign srv_rd_en  = (in_acc && is_tick) || (proc_go && !is_last);
  assign qcmd.rd    = srv_rd_en;
  assign srv_rd_idx = (state_r == ST_PROC) ? SAW'(idx_r + 1'b1) : '0;

  fcd_call_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (qcmd),
    .push_id (in_ch.call_id),
    .count   (q_count),
    .head_id (q_head)
  );

  fcd_server_store #(
    .NSRV (NSRV)
  ) u_servers (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (srv_rd_en),
    .rd_idx (srv_rd_idx),
    .wr_en  (proc_go),
    .wr_idx (idx_r),
    .wr_rec (srv_wr),
    .rd_rec (srv_rd)
  );

  // Sequencer and result register next values
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    last_nxt     = last_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_acc_nxt  = out_acc_r;
    out_sidx_nxt = out_sidx_r;
    out_asg_nxt  = out_asg_r;
    out_aid_nxt  = out_aid_r;
    out_busy_nxt = out_busy_r;
    out_tot_nxt  = out_tot_r;
    out_lvl_nxt  = out_lvl_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_tick) begin
          // Start the visit at server 0
          idx_nxt   = '0;
          last_nxt  = SAW'(n_lim - 1'b1);
          state_nxt = ST_PROC;
        end else if (in_acc) begin
          // Enqueue result
          out_vld_nxt  = 1'b1;
          out_acc_nxt  = !q_full;
          out_sidx_nxt = '0;
          out_asg_nxt  = 1'b0;
          out_aid_nxt  = '0;
          out_busy_nxt = 1'b0;
          out_tot_nxt  = '0;
          out_lvl_nxt  = LVW'(q_full ? q_count : q_count + 1'b1);
          out_last_nxt = 1'b1;
        end
      end
      ST_PROC: begin
        if (proc_go) begin
          // Server status result
          out_vld_nxt  = 1'b1;
          out_acc_nxt  = 1'b0;
          out_sidx_nxt = SIW'(idx_r);
          out_asg_nxt  = take;
          out_aid_nxt  = take ? q_head : '0;
          out_busy_nxt = srv_wr.busy;
          out_tot_nxt  = srv_wr.total;
          out_lvl_nxt  = LVW'(take ? q_count - 1'b1 : q_count);
          out_last_nxt = is_last;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = SAW'(idx_r + 1'b1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      idx_r     <= '0;
      last_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      idx_r     <= idx_nxt;
      last_r    <= last_nxt;
    end
    out_acc_r  <= out_acc_nxt;
    out_sidx_r <= out_sidx_nxt;
    out_asg_r  <= out_asg_nxt;
    out_aid_r  <= out_aid_nxt;
    out_busy_r <= out_busy_nxt;
    out_tot_r  <= out_tot_nxt;
    out_lvl_r  <= out_lvl_nxt;
    out_last_r <= out_last_nxt;
  end

  // Drive the result channel
  assign out_ch.valid            = out_vld_r;
  assign out_ch.enqueue_accepted = out_acc_r;
  assign out_ch.server_index     = out_sidx_r;
  assign out_ch.call_assigned    = out_asg_r;
  assign out_ch.assigned_call_id = out_aid_r;
  assign out_ch.server_busy      = out_busy_r;
  assign out_ch.calls_handled    = out_tot_r;
  assign out_ch.queue_level      = out_lvl_r;
  assign out_ch.last_result      = out_last_r;

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for fifo_call_dispatcher: enqueue and tick requests, server status.
// Depends on fcd_pkg, the fcd_in_if / fcd_out_if interfaces and fifo_call_dispatcher.
module testbench;
  import fcd_pkg::*;

  localparam int QDEPTH     = QUEUE_DEPTH_DEF;
  localparam int NSRV       = MAX_SERVERS_DEF;
  localparam int SETTLE     = 12;    // quiet cycles before a register write or a drain point
  localparam int TAIL_WAIT  = 20;    // cycles after the last status arrives
  localparam int STALL_MAX  = 5000;  // cycles with no handshake before giving up
  localparam int SHOW_MAX   = 40;    // mismatch lines printed, the rest only counted

  // Receiver stall styles
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} rdy_mode_t;

  // One status item as the dispatcher should report it
  typedef struct packed {
    logic                 enq_ok;
    logic [SRV_IDX_W-1:0] srv;
    logic                 took;
    logic [ID_W-1:0]      took_id;
    logic                 busy;
    logic [TOTAL_W-1:0]   handled;
    logic [LEVEL_W-1:0]   level;
    logic                 last;
  } srv_status_t;

  // One planned step: a request item or a register write
  typedef struct {
    logic                  is_write;
    logic                  drain_first;
    logic                  req;
    logic [ID_W-1:0]       id;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } plan_step_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  fcd_in_if  req_bus ();
  fcd_out_if sts_bus ();

  fifo_call_dispatcher i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (req_bus),
    .out_ch   (sts_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Shadow of the dispatcher: configuration, call queue and servers
  logic [TIME_W-1:0]    svc_time = SERVICE_TIME_RST;
  logic [SRV_CNT_W-1:0] srv_cnt  = SERVERS_RST;
  logic [ID_W-1:0]      q_mem [QDEPTH];
  int                   q_head   = 0;
  int                   q_tail   = 0;
  int                   q_count  = 0;
  logic                 srv_busy  [NSRV] = '{default: 1'b0};
  logic [TIME_W-1:0]    srv_left  [NSRV] = '{default: '0};
  logic [TOTAL_W-1:0]   srv_total [NSRV] = '{default: '0};

  plan_step_t  request_plan [$];
  srv_status_t status_due [$];

  int items_sent     = 0;
  int items_taken    = 0;
  int burst_left     = 1;
  int gap_left       = 0;
  int quiet_cycles   = 0;
  int stall_cycles   = 0;
  int ready_window   = 0;
  int ready_phase    = 0;
  rdy_mode_t ready_mode = RDY_ALWAYS;

  int fail_count     = 0;
  int calls_stored   = 0;
  int calls_dropped  = 0;
  int ticks_done     = 0;
  int calls_assigned = 0;
  int reg_writes     = 0;
  int status_checked = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Count a failure and print it while the log is still short
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= SHOW_MAX)
      $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      note_failure($sformatf("status %0d field %s: got 0x%0h, want 0x%0h",
                             status_checked, field, got, want));
  endtask

  // Work out the status items caused by one accepted request
  task automatic predict_dispatch(input logic req, input logic [ID_W-1:0] id);
    srv_status_t       st;
    int                n;
    logic [TIME_W-1:0] load;
    if (req == REQ_ENQUEUE) begin
      st = '0;
      if (q_count < QDEPTH) begin
        q_mem[q_tail] = id;
        q_tail = (q_tail + 1) % QDEPTH;
        q_count++;
        st.enq_ok = 1'b1;
        calls_stored++;
      end else begin
        calls_dropped++;
      end
      st.level = LEVEL_W'(q_count);
      st.last  = 1'b1;
      status_due.push_back(st);
    end else begin
      ticks_done++;
      n = (srv_cnt == 0) ? 1 : int'(srv_cnt);
      if (n > NSRV) n = NSRV;
      if (n > RESULT_LIMIT) n = RESULT_LIMIT;
      load = (svc_time == 0) ? TIME_W'(1) : svc_time;
      for (int s = 0; s < n; s++) begin
        st = '0;
        // count down, free at zero
        if (srv_busy[s]) begin
          if (srv_left[s] != 0) srv_left[s]--;
          if (srv_left[s] == 0) srv_busy[s] = 1'b0;
        end
        // a free server takes the head call at once
        if (!srv_busy[s] && q_count > 0) begin
          st.took    = 1'b1;
          st.took_id = q_mem[q_head];
          q_head = (q_head + 1) % QDEPTH;
          q_count--;
          srv_busy[s] = 1'b1;
          srv_left[s] = load;
          if (srv_total[s] != TOTAL_MAX) srv_total[s]++;
          calls_assigned++;
        end
        st.srv     = SRV_IDX_W'(s);
        st.busy    = srv_busy[s];
        st.handled = srv_total[s];
        st.level   = LEVEL_W'(q_count);
        st.last    = (s == n - 1);
        status_due.push_back(st);
      end
    end
  endtask

  // Plan building
  task automatic plan_item(input logic req, input logic [ID_W-1:0] id, input logic drain);
    plan_step_t p;
    p = '{is_write: 1'b0, drain_first: drain, req: req, id: id, idx: '0, data: '0};
    request_plan.push_back(p);
  endtask

  task automatic plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    plan_step_t p;
    p = '{is_write: 1'b1, drain_first: 1'b1, req: 1'b0, id: '0, idx: idx, data: data};
    request_plan.push_back(p);
  endtask

  // Random mix of calls and ticks, with one drain point somewhere inside
  task automatic plan_mix(input int count, input int tick_pct);
    int hold_at;
    hold_at = $urandom_range(0, count - 1);
    for (int k = 0; k < count; k++)
      plan_item(($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_ENQUEUE,
                ID_W'($urandom), k == hold_at);
  endtask

  // Driver: bursts of items with random gaps, register writes only when idle
  always @(negedge clk) begin : drive_requests
    logic                  v_nx;
    logic                  req_nx;
    logic [ID_W-1:0]       id_nx;
    logic                  we_nx;
    logic [CFG_IDX_W-1:0]  idx_nx;
    logic [CFG_DATA_W-1:0] data_nx;
    plan_step_t            step;
    v_nx    = req_bus.valid;
    req_nx  = req_bus.req_type;
    id_nx   = req_bus.call_id;
    we_nx   = 1'b0;
    idx_nx  = cfg_idx;
    data_nx = cfg_data;
    if (rst_n) begin
      // retire the item taken at the last edge
      if (req_bus.valid && items_taken == items_sent) begin
        v_nx = 1'b0;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!req_bus.valid && !cfg_we && status_due.size() == 0)
        quiet_cycles++;
      else
        quiet_cycles = 0;
      // advance the plan
      if (!v_nx) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_plan.size() > 0) begin
          step = request_plan[0];
          if (step.is_write) begin
            if (quiet_cycles >= SETTLE) begin
              we_nx   = 1'b1;
              idx_nx  = step.idx;
              data_nx = step.data;
              quiet_cycles = 0;
              void'(request_plan.pop_front());
            end
          end else if (!step.drain_first || quiet_cycles >= SETTLE) begin
            v_nx   = 1'b1;
            req_nx = step.req;
            id_nx  = step.id;
            items_sent++;
            void'(request_plan.pop_front());
          end
        end
      end
    end
    req_bus.valid    <= v_nx;
    req_bus.req_type <= req_nx;
    req_bus.call_id  <= id_nx;
    cfg_we           <= we_nx;
    cfg_idx          <= idx_nx;
    cfg_data         <= data_nx;
  end

  // Receiver: stall style picked anew at the end of each randomly sized window
  always @(negedge clk) begin : drive_ready
    if (ready_window == 0) begin
      ready_mode   = rdy_mode_t'($urandom_range(0, 2));
      ready_window = $urandom_range(16, 64);
    end else begin
      ready_window--;
    end
    ready_phase++;
    case (ready_mode)
      RDY_ALWAYS: begin
        sts_bus.ready <= 1'b1;
      end
      RDY_RANDOM: begin
        sts_bus.ready <= ($urandom_range(0, 2) != 0);
      end
      default: begin
        sts_bus.ready <= ((ready_phase % 5) < 2);
      end
    endcase
  end

  // Monitor: track writes, predict on accepted items, check accepted status items
  always @(posedge clk) begin : watch_ports
    srv_status_t want;
    logic        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_we) begin
        reg_writes++;
        if (cfg_idx == CFG_SERVICE_TIME)
          svc_time = cfg_data[TIME_W-1:0];
        else if (cfg_idx == CFG_SERVERS_IN_USE)
          srv_cnt = cfg_data[SRV_CNT_W-1:0];
      end
      if (req_bus.valid && req_bus.ready) begin
        predict_dispatch(req_bus.req_type, req_bus.call_id);
        items_taken++;
        moved = 1'b1;
      end
      if (sts_bus.valid && sts_bus.ready) begin
        moved = 1'b1;
        if (status_due.size() == 0) begin
          note_failure($sformatf("status item with none expected (server %0d)",
                                 sts_bus.server_index));
        end else begin
          want = status_due.pop_front();
          check_field("enqueue_accepted", sts_bus.enqueue_accepted, want.enq_ok);
          check_field("server_index",     sts_bus.server_index,     want.srv);
          check_field("call_assigned",    sts_bus.call_assigned,    want.took);
          check_field("assigned_call_id", sts_bus.assigned_call_id, want.took_id);
          check_field("server_busy",      sts_bus.server_busy,      want.busy);
          check_field("calls_handled",    sts_bus.calls_handled,    want.handled);
          check_field("queue_level",      sts_bus.queue_level,      want.level);
          check_field("last_result",      sts_bus.last_result,      want.last);
        end
        status_checked++;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog: give up when no handshake happens for too long
  initial begin : watchdog
    while (stall_cycles < STALL_MAX) @(posedge clk);
    $display("Timeout: %0d status items still expected, %0d steps unsent",
             status_due.size(), request_plan.size());
    $display("** fifo_call_dispatcher: FAILED **");
    $finish;
  end

  // Plan, reset, wait for drain, report
  initial begin : run_test
    rst_n            = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_ENQUEUE;
    req_bus.call_id  = '0;
    sts_bus.ready    = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_SERVICE_TIME;
    cfg_data         = '0;

    // Directed, reset settings: tick on an empty queue, id extremes, servers
    // filling up, and servers freed after the full service time and reused
    plan_item(REQ_TICK, '0, 1'b0);
    plan_item(REQ_ENQUEUE, 16'h0000, 1'b0);
    plan_item(REQ_ENQUEUE, 16'hFFFF, 1'b0);
    plan_item(REQ_ENQUEUE, 16'h5A5A, 1'b0);
    plan_item(REQ_ENQUEUE, 16'hA5A5, 1'b0);
    plan_item(REQ_TICK, '0, 1'b0);
    for (int k = 0; k < 8; k++) plan_item(REQ_ENQUEUE, ID_W'($urandom), 1'b0);
    for (int k = 0; k < 11; k++) plan_item(REQ_TICK, ID_W'($urandom), 1'b0);

    // Zero service time and zero server count, high data bits set at random
    plan_write(CFG_SERVICE_TIME, '0);
    plan_write(CFG_SERVERS_IN_USE, {12'($urandom), 4'h0});
    plan_mix(8, 40);

    // One tick per call, oversized server count; fill past full, then drain
    plan_write(CFG_SERVICE_TIME, 16'd1);
    plan_write(CFG_SERVERS_IN_USE, 16'hFFFF);
    plan_item(REQ_ENQUEUE, ID_W'($urandom), 1'b1);
    for (int k = 0; k < QDEPTH + 3; k++) plan_item(REQ_ENQUEUE, ID_W'($urandom), 1'b0);
    for (int k = 0; k < 18; k++) plan_item(REQ_TICK, '0, 1'b0);

    // Mid-range settings, server counts inside and above the pool size
    plan_write(CFG_SERVICE_TIME, CFG_DATA_W'($urandom_range(2, 9)));
    plan_write(CFG_SERVERS_IN_USE, {12'($urandom), 4'($urandom_range(1, 8))});
    plan_mix(8, 35);
    plan_write(CFG_SERVICE_TIME, CFG_DATA_W'($urandom_range(1, 4)));
    plan_write(CFG_SERVERS_IN_USE, {12'($urandom), 4'($urandom_range(9, 15))});
    plan_mix(8, 55);
    plan_write(CFG_SERVERS_IN_USE, {12'($urandom), 4'($urandom_range(1, 3))});
    plan_mix(6, 30);

    // Longest service time last, so busy servers never hold up later phases
    plan_write(CFG_SERVICE_TIME, 16'hFFFF);
    plan_write(CFG_SERVERS_IN_USE, 16'd3);
    plan_mix(6, 50);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (request_plan.size() != 0 || req_bus.valid || status_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Covered %0d requests: %0d calls stored, %0d dropped on a full queue, %0d ticks,",
             items_taken, calls_stored, calls_dropped, ticks_done);
    $display("%0d calls handed to servers, %0d register writes, %0d status items checked",
             calls_assigned, reg_writes, status_checked);
    if (fail_count == 0) begin
      $display("** fifo_call_dispatcher: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** fifo_call_dispatcher: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/fcd_pkg.sv
design/fcd_in_if.sv
design/fcd_out_if.sv
design/fcd_ram.sv
design/fcd_call_queue.sv
design/fcd_server_store.sv
design/fifo_call_dispatcher.sv
verif/testbench.sv
